>>> rtl/bal_pkg.sv
// Shared types and constants for the bounded array list core.
package bal_pkg;

    // Default number of entries the list can hold.
    localparam int CAPACITY_DEFAULT = 16;

    // Number of cells merged by one register of the read tree.
    localparam int GROUP_SIZE = 16;

    // Operation codes carried on the op port.
    typedef enum logic [2:0] {
        OP_INSERT_AT    = 3'd0,
        OP_INSERT_REAR  = 3'd1,
        OP_DELETE_FRONT = 3'd2,
        OP_DELETE_REAR  = 3'd3,
        OP_READ         = 3'd4
    } op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_MERGE
    } state_t;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic ins_en;      // a successful insert: load or shift up
        logic shift_down;  // a successful delete at the front
    } cell_ctrl_t;

endpackage

>>> rtl/bounded_array_list_core.sv
// Top level of the bounded array list: decode, fill count, cell row and read tree.
//
// Usage. An item (op, position, value) is taken at a rising edge where start is
// high and busy is low. Every item gives exactly one result on ok, fill_count and
// read_value, shown for a single cycle with done high. The receiver cannot hold
// a result off, so it must capture it in the cycle that done is high.
//
// Inserts, deletes and failed reads are decided in the accepting cycle: every
// cell of the row shifts, loads or holds at that same edge, and the result
// appears in the following cycle. Such items may be issued in every cycle, as
// busy stays low for them.
//
// A successful read gathers the addressed entry through a registered OR tree:
// the read position is registered, then each group selects among its cells into
// a group register, and the group registers are merged into the result register.
// busy stays high in between, so no new item is taken until the read completes.
//
// Reset clears the fill count and the sequencer; the entry storage is not
// cleared, since only entries below the count can ever be read.
module bounded_array_list_core
    import bal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic [4:0]         position,
    input  logic signed [31:0] value,
    output logic               done,
    output logic               ok,
    output logic [4:0]         fill_count,
    output logic signed [31:0] read_value
);

    // Widths of an entry index, of the count, and of the common compare width.
    localparam int IW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int LW     = (CW > 5) ? CW : 5;
    localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           done_reg, done_next;
    logic           ok_reg, ok_next;
    logic [31:0]    rdv_reg, rdv_next;
    logic [IW-1:0]  pos_reg, pos_next;
    logic [31:0]    grp_reg [NGROUP];
    logic [31:0]    grp_next [NGROUP];

    logic           accept;
    cell_ctrl_t     ctrl;
    logic [IW-1:0]  ins_pos;
    logic [LW-1:0]  cnt_ext;
    logic [LW-1:0]  pos_ext;
    logic           not_full;
    logic           not_empty;
    logic [31:0]    cell_data [CAPACITY];
    logic [31:0]    cell_sel [CAPACITY];

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign cnt_ext = LW'(count_reg);
    assign pos_ext = LW'(position);
    assign not_full  = (count_reg < CW'(CAPACITY));
    assign not_empty = (count_reg != '0);

    // Decode of the item and the sequencer for the read tree.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        ok_next     = ok_reg;
        rdv_next    = rdv_reg;
        pos_next    = pos_reg;
        ctrl        = '0;
        ins_pos     = count_reg[IW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    ok_next   = 1'b0;
                    rdv_next  = 32'd0;
                    unique case (op_t'(op))
                        OP_INSERT_AT:
                        begin
                            ins_pos = pos_ext[IW-1:0];
                            if (not_full && (pos_ext <= cnt_ext))
                            begin
                                ctrl.ins_en = 1'b1;
                                count_next  = count_reg + CW'(1);
                                ok_next     = 1'b1;
                            end
                        end
                        OP_INSERT_REAR:
                        begin
                            if (not_full)
                            begin
                                ctrl.ins_en = 1'b1;
                                count_next  = count_reg + CW'(1);
                                ok_next     = 1'b1;
                            end
                        end
                        OP_DELETE_FRONT:
                        begin
                            if (not_empty)
                            begin
                                ctrl.shift_down = 1'b1;
                                count_next      = count_reg - CW'(1);
                                ok_next         = 1'b1;
                            end
                        end
                        OP_DELETE_REAR:
                        begin
                            if (not_empty)
                            begin
                                count_next = count_reg - CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            // A read that hits waits for the tree; a miss
                            // answers at once with a zero word.
                            if (pos_ext < cnt_ext)
                            begin
                                done_next  = 1'b0;
                                pos_next   = pos_ext[IW-1:0];
                                state_next = ST_GATHER;
                            end
                        end
                        default:
                        begin
                            // Unused codes change nothing and fail.
                        end
                    endcase
                end
            end
            ST_GATHER:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                rdv_next = 32'd0;
                for (int g = 0; g < NGROUP; g++)
                begin
                    rdv_next = rdv_next | grp_reg[g];
                end
                ok_next    = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // First level of the read tree: each group ORs its selected cells.
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_next[g] = 32'd0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | cell_sel[g * GROUP_SIZE + k];
                end
            end
        end
    end

    // The row of cells; each sees its neighbours below and above.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0] lower;
        logic [31:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = 32'd0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = cell_data[i];
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[i+1];
        end

        bal_cell #(
            .INDEX (i),
            .IW    (IW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .ins_pos    (ins_pos),
            .rd_pos     (pos_reg),
            .value      (value),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_data[i]),
            .sel_data   (cell_sel[i])
        );
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ok_reg  <= ok_next;
        rdv_reg <= rdv_next;
        pos_reg <= pos_next;
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign fill_count = cnt_ext[4:0];
    assign read_value = rdv_reg;

    // The count only moves when an item is taken.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("fill count moved without an item");

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // A gathered read always completes successfully once the merge state has passed.
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GATHER) |=> ##1 (done && ok && !busy))
        else $error("read did not complete in time");

    // A failed result never carries a word.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (read_value == 32'sd0))
        else $error("failed item returned a word");

    // A result strobe follows only an accepted item or the end of a read.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(accept) || $past(state_reg == ST_MERGE)))
        else $error("result without a cause");

endmodule

>>> rtl/bal_cell.sv
// One storage cell of the list row, holding a single entry.
module bal_cell
    import bal_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IW    = 4
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [IW-1:0]     ins_pos,
    input  logic [IW-1:0]     rd_pos,
    input  logic [31:0]       value,
    input  logic [31:0]       lower_data,
    input  logic [31:0]       upper_data,
    output logic [31:0]       data,
    output logic [31:0]       sel_data
);

    localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;

    // Each cell decides for itself whether to load, take a neighbour or hold.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            if (MY_INDEX == ins_pos)
            begin
                entry_next = value;
            end
            else if (MY_INDEX > ins_pos)
            begin
                entry_next = lower_data;
            end
        end
        else if (ctrl.shift_down)
        begin
            entry_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data     = entry_reg;
    assign sel_data = (MY_INDEX == rd_pos) ? entry_reg : 32'd0;

endmodule
